>>> src/jsu_pkg.sv
package jsu_pkg;

  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_mag;
    logic red_init;
    logic red_loop;
    logic halve;
    logic swap;
  } jsu_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic m_one;
    logic m_two;
    logic val_odd;
    logic a_zero;
    logic a_odd;
    logic neg;
    logic div_done;
  } jsu_stat_t;

endpackage

>>> src/jsu_div.sv
module jsu_div import jsu_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] dividend,
  input  logic [WORD_WIDTH-2:0] divisor,
  output logic                  done,
  output logic [WORD_WIDTH-2:0] rem
);

  localparam int CW = $clog2(WORD_WIDTH + 1);

  logic [WORD_WIDTH-1:0] q_r;
  logic [WORD_WIDTH-2:0] rem_r;
  logic [WORD_WIDTH-2:0] dv_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [WORD_WIDTH-1:0] sh;
  logic [WORD_WIDTH-1:0] diff;
  logic                  ge;

  assign sh   = {rem_r, q_r[WORD_WIDTH-1]};
  assign ge   = sh >= {1'b0, dv_r};
  assign diff = sh - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WORD_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[WORD_WIDTH-2:0], 1'b0};
      rem_r <= ge ? diff[WORD_WIDTH-2:0] : sh[WORD_WIDTH-2:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> src/jsu_dp.sv
module jsu_dp import jsu_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jsu_cmd_t              cmd,
  input  logic [WORD_WIDTH-1:0] in_value_a,
  input  logic [WORD_WIDTH-2:0] in_modulus,
  output jsu_stat_t             stat
);

  logic [WORD_WIDTH-1:0] val_r;
  logic [WORD_WIDTH-2:0] a_r;
  logic [WORD_WIDTH-2:0] m_r;
  logic                  neg_r;
  logic                  neg_nxt;
  logic [WORD_WIDTH-1:0] mag;
  logic [WORD_WIDTH-1:0] div_a;
  logic [WORD_WIDTH-2:0] div_m;
  logic [WORD_WIDTH-2:0] rem;
  logic                  div_done;
  logic                  m38;
  logic                  both3;

  assign mag   = val_r[WORD_WIDTH-1] ? (~val_r + 1'b1) : val_r;
  assign div_a = cmd.div_mag ? mag : {1'b0, a_r};
  assign div_m = m_r;
  assign m38   = (m_r[2:0] == 3'd3) || (m_r[2:0] == 3'd5);
  assign both3 = (a_r[1:0] == 2'd3) && (m_r[1:0] == 2'd3);

  jsu_div #(.WORD_WIDTH(WORD_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_m),
    .done     (div_done),
    .rem      (rem)
  );

  always_comb begin
    neg_nxt = neg_r;
    if (cmd.load) begin
      neg_nxt = 1'b0;
    end else if (cmd.halve && m38) begin
      neg_nxt = ~neg_r;
    end else if (cmd.swap && both3) begin
      neg_nxt = ~neg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r <= 1'b0;
    end else begin
      neg_r <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_value_a;
      m_r   <= in_modulus;
      a_r   <= '0;
    end else if (cmd.red_init) begin
      a_r <= (val_r[WORD_WIDTH-1] && (rem != '0)) ? (m_r - rem) : rem;
    end else if (cmd.red_loop) begin
      a_r <= rem;
    end else if (cmd.halve) begin
      a_r <= {1'b0, a_r[WORD_WIDTH-2:1]};
    end else if (cmd.swap) begin
      a_r <= m_r;
      m_r <= a_r;
    end
  end

  assign stat.m_zero   = (m_r == '0);
  assign stat.m_one    = (m_r == (WORD_WIDTH-1)'(1));
  assign stat.m_two    = (m_r == (WORD_WIDTH-1)'(2));
  assign stat.val_odd  = val_r[0];
  assign stat.a_zero   = (a_r == '0);
  assign stat.a_odd    = a_r[0];
  assign stat.neg      = neg_r;
  assign stat.div_done = div_done;

endmodule

>>> src/jsu_ctrl.sv
module jsu_ctrl import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  jsu_stat_t stat,
  output jsu_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid,
  output logic [1:0] out_symbol
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLASS   = 3'd1;
  localparam logic [2:0] S_RED0    = 3'd2;
  localparam logic [2:0] S_LOOP    = 3'd3;
  localparam logic [2:0] S_DIVGO   = 3'd4;
  localparam logic [2:0] S_DIVWAIT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic [1:0] sym_r;
  logic [1:0] sym_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    sym_nxt   = sym_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stat.m_zero) begin
          valid_nxt = 1'b1;
          sym_nxt   = SYM_ZERO;
          state_nxt = S_IDLE;
        end else if (stat.m_one) begin
          valid_nxt = 1'b1;
          sym_nxt   = SYM_POS;
          state_nxt = S_IDLE;
        end else if (stat.m_two) begin
          valid_nxt = 1'b1;
          sym_nxt   = stat.val_odd ? SYM_POS : SYM_ZERO;
          state_nxt = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_mag   = 1'b1;
          state_nxt     = S_RED0;
        end
      end
      S_RED0: begin
        if (stat.div_done) begin
          cmd.red_init = 1'b1;
          state_nxt    = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat.a_zero) begin
          valid_nxt = 1'b1;
          sym_nxt   = !stat.m_one ? SYM_ZERO : (stat.neg ? SYM_NEG : SYM_POS);
          state_nxt = S_IDLE;
        end else if (!stat.a_odd) begin
          cmd.halve = 1'b1;
        end else begin
          cmd.swap  = 1'b1;
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (stat.div_done) begin
          cmd.red_loop = 1'b1;
          state_nxt    = S_LOOP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = valid_r;
  assign out_symbol = sym_r;

endmodule

>>> src/jacobi_symbol_unit.sv
// A modulus of 0, 1 or 2 is answered straight from the classification state; otherwise the value
// is first reduced, then factors of two are removed and each Euclid step swaps and reduces, then the result.
// Throughput: one item at a time; busy stays high until the result strobe.
// The remainder unit retires one quotient bit per cycle and sets the rate.
// out_valid pulses for one cycle; the receiver cannot stall it.
// Reset: synchronous, active-low rst_n returns the controller to idle.
module jacobi_symbol_unit import jsu_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [WORD_WIDTH-1:0] in_value_a,
  input  logic [WORD_WIDTH-2:0] in_modulus,
  output logic                  out_valid,
  output logic [1:0]            out_symbol
);

  jsu_cmd_t  cmd;
  jsu_stat_t stat;

  jsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_symbol (out_symbol)
  );

  jsu_dp #(.WORD_WIDTH(WORD_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value_a (in_value_a),
    .in_modulus (in_modulus),
    .stat       (stat)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_valid_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_symbol == SYM_ZERO || out_symbol == SYM_POS || out_symbol == SYM_NEG))
    else $error("illegal symbol code");

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
